[src/mbtcp_pkg.sv]
package mbtcp_pkg;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_RX      = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_BAD_ARG  = 4'd1;
    localparam logic [3:0] ST_TIMEOUT  = 4'd2;
    localparam logic [3:0] ST_TID      = 4'd3;
    localparam logic [3:0] ST_PROTO    = 4'd4;
    localparam logic [3:0] ST_LENGTH   = 4'd5;
    localparam logic [3:0] ST_UNIT     = 4'd6;
    localparam logic [3:0] ST_EXCEPT   = 4'd7;
    localparam logic [3:0] ST_FUNCTION = 4'd8;
    localparam logic [3:0] ST_SIZE     = 4'd9;

    localparam logic [7:0]  EXC_FLAG = 8'h80;
    localparam logic [15:0] MAX_QTY  = 16'd125;
    localparam logic [15:0] MAX_LEN  = 16'd253;
    localparam logic [7:0]  COIL_CNT = 8'h01;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // command from the front part to the back part
    typedef struct packed {
        logic        frame;     // emit 12-byte request; with status kind, a value first
        logic [15:0] tid;
        logic [7:0]  unit;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] word;
        logic [1:0]  kind;      // single result when frame is low
        logic [15:0] data;
        logic [3:0]  status;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
        logic [3:0]  status;
        logic        last;
    } res_t;

endpackage

[src/mbtcp_front.sv]
module mbtcp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [7:0]        device_id,
    input  logic [7:0]        function_req,
    input  logic [15:0]       address,
    input  logic [15:0]       word,
    input  logic [7:0]        rx_byte,
    output logic              cmd_valid,
    output mbtcp_pkg::cmd_t   cmd,
    input  logic              cmd_full
);
    import mbtcp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        link_reg, link_next;
    logic [15:0] tcnt_reg, tcnt_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  flen_reg, flen_next;
    logic [7:0]  unit_reg, unit_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] word_reg, word_next;
    logic [7:0]  high_reg, high_next;
    logic [3:0]  perr_reg, perr_next;

    logic        fire, args_ok, is_read, is_rd_fn;
    logic [15:0] hword, base_cnt;
    logic [8:0]  want_len, twice_word;
    logic [3:0]  st;
    logic [7:0]  echo_want;

    assign in_ready = !cmd_full;
    assign fire     = in_valid && in_ready;
    assign hword    = {high_reg, rx_byte};
    assign is_rd_fn = function_req == 8'd3 || function_req == 8'd4;
    assign args_ok  = function_req == 8'd1 || function_req == 8'd5 || function_req == 8'd6 ||
                      (is_rd_fn && word >= 16'd1 && word <= MAX_QTY);
    assign base_cnt = link_reg ? tcnt_reg : 16'd0;
    assign is_read  = func_reg == 8'd3 || func_reg == 8'd4;
    // quantity is at most 125 on reads, so 9 bits hold twice of it
    assign twice_word = {word_reg[7:0], 1'b0};
    assign want_len = is_read ? twice_word + 9'd3 : (func_reg == 8'd1 ? 9'd4 : 9'd6);

    always_comb
    begin
        case (idx_reg)
            8'd2:    echo_want = addr_reg[15:8];
            8'd3:    echo_want = addr_reg[7:0];
            8'd4:    echo_want = word_reg[15:8];
            default: echo_want = word_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        link_next  = link_reg;
        tcnt_next  = tcnt_reg;
        idx_next   = idx_reg;
        flen_next  = flen_reg;
        unit_next  = unit_reg;
        func_next  = func_reg;
        addr_next  = addr_reg;
        word_next  = word_reg;
        high_next  = high_reg;
        perr_next  = perr_reg;
        st         = perr_reg;
        cmd_valid  = 1'b0;
        cmd        = '0;
        cmd.tid    = base_cnt + 16'd1;
        cmd.unit   = device_id;
        cmd.func   = function_req;
        cmd.addr   = address;
        cmd.word   = (function_req == 8'd1) ? 16'd1 : word;
        if (fire) begin
            case (action)
                ACT_START:
                begin
                    cmd_valid = 1'b1;
                    if (!args_ok) begin
                        cmd.kind   = KIND_STATUS;
                        cmd.status = ST_BAD_ARG;
                    end else begin
                        cmd.frame  = 1'b1;
                        link_next  = 1'b1;
                        tcnt_next  = cmd.tid;
                        unit_next  = device_id;
                        func_next  = function_req;
                        addr_next  = address;
                        word_next  = cmd.word;
                        phase_next = PH_HEADER;
                        idx_next   = '0;
                        flen_next  = '0;
                        high_next  = '0;
                        perr_next  = ST_OK;
                    end
                end
                ACT_RX:
                begin
                    if (phase_reg == PH_HEADER) begin
                        idx_next = idx_reg + 8'd1;
                        st = perr_reg;
                        if (!idx_reg[0]) begin
                            high_next = rx_byte;
                        end else if (perr_reg == ST_OK) begin
                            if (idx_reg == 8'd1 && hword != tcnt_reg)
                                st = ST_TID;
                            else if (idx_reg == 8'd3 && hword != 16'd0)
                                st = ST_PROTO;
                            else if (idx_reg == 8'd5 && (hword < 16'd2 || hword > MAX_LEN))
                                st = ST_LENGTH;
                        end
                        perr_next = st;
                        if (idx_reg == 8'd5) begin
                            if (st != ST_OK) begin
                                link_next  = 1'b0;
                                phase_next = PH_IDLE;
                                cmd_valid  = 1'b1;
                                cmd.kind   = KIND_STATUS;
                                cmd.status = st;
                            end else begin
                                flen_next  = hword[7:0];
                                phase_next = PH_BODY;
                                idx_next   = '0;
                            end
                        end
                    end else if (phase_reg == PH_BODY) begin
                        idx_next = idx_reg + 8'd1;
                        st = perr_reg;
                        if (perr_reg == ST_OK) begin
                            if (idx_reg == 8'd0) begin
                                if (rx_byte != unit_reg)
                                    st = ST_UNIT;
                            end else if (idx_reg == 8'd1) begin
                                if (rx_byte == (func_reg | EXC_FLAG)) begin
                                    st = ST_EXCEPT;
                                    high_next = '0;
                                end else if (rx_byte != func_reg) begin
                                    st = ST_FUNCTION;
                                end else if ({1'b0, flen_reg} != want_len) begin
                                    st = ST_SIZE;
                                end
                            end else if (is_read) begin
                                if (idx_reg == 8'd2) begin
                                    if ({1'b0, rx_byte} != twice_word)
                                        st = ST_SIZE;
                                end else if (idx_reg[0]) begin
                                    high_next = rx_byte;
                                end else begin
                                    cmd_valid = 1'b1;
                                    cmd.kind  = KIND_VALUE;
                                    cmd.data  = hword;
                                end
                            end else if (func_reg == 8'd1) begin
                                if (idx_reg == 8'd2) begin
                                    if (rx_byte != COIL_CNT)
                                        st = ST_SIZE;
                                end else begin
                                    cmd_valid = 1'b1;
                                    cmd.kind  = KIND_VALUE;
                                    cmd.data  = {15'd0, rx_byte[0]};
                                end
                            end else if (rx_byte != echo_want) begin
                                st = ST_SIZE;
                            end
                        end else if (perr_reg == ST_EXCEPT && idx_reg == 8'd2) begin
                            high_next = rx_byte;
                        end
                        perr_next = st;
                        // the last byte of a read or coil reply carries a value and the
                        // final status; merge both into one command
                        if ({1'b0, idx_reg} + 9'd1 >= {1'b0, flen_reg}) begin
                            if (st >= ST_TID && st <= ST_FUNCTION)
                                link_next = 1'b0;
                            phase_next = PH_IDLE;
                            cmd_valid  = 1'b1;
                            cmd.frame  = cmd.kind == KIND_VALUE;
                            cmd.kind   = KIND_STATUS;
                            cmd.status = st;
                            cmd.data   = (st == ST_EXCEPT) ? {8'd0, high_next}
                                         : (cmd.frame ? cmd.data : 16'd0);
                        end
                    end
                end
                ACT_TIMEOUT:
                begin
                    if (phase_reg != PH_IDLE) begin
                        link_next  = 1'b0;
                        phase_next = PH_IDLE;
                        cmd_valid  = 1'b1;
                        cmd.kind   = KIND_STATUS;
                        cmd.status = ST_TIMEOUT;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            link_reg  <= 1'b0;
            tcnt_reg  <= '0;
            idx_reg   <= '0;
            flen_reg  <= '0;
            unit_reg  <= '0;
            func_reg  <= '0;
            addr_reg  <= '0;
            word_reg  <= '0;
            high_reg  <= '0;
            perr_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            link_reg  <= link_next;
            tcnt_reg  <= tcnt_next;
            idx_reg   <= idx_next;
            flen_reg  <= flen_next;
            unit_reg  <= unit_next;
            func_reg  <= func_next;
            addr_reg  <= addr_next;
            word_reg  <= word_next;
            high_reg  <= high_next;
            perr_reg  <= perr_next;
        end
    end

    property p_idle_no_err;
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER && idx_reg == 8'd0) |-> perr_reg == ST_OK;
    endproperty
    a_idle_no_err: assert property (p_idle_no_err) else $error("stale error at header start");

    a_no_cmd_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> !cmd_full) else $error("command pushed into full queue");

    a_start_open: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.frame && cmd.kind == KIND_FRAME) |=> link_reg)
        else $error("link not open after request");

endmodule

[src/mbtcp_back.sv]
module mbtcp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  mbtcp_pkg::cmd_t   cmd,
    output logic              cmd_full,
    output logic              out_valid,
    input  logic              out_ready,
    output mbtcp_pkg::res_t   res
);
    import mbtcp_pkg::*;

    cmd_t        q_mem [QDEPTH];
    logic [QAW:0] wp_reg, rp_reg;
    logic [QAW:0] count;
    logic        q_empty;
    cmd_t        head;
    logic [3:0]  sub_reg, sub_next;
    logic        pop, adv;
    logic [7:0]  fbyte;
    logic        two_part;

    assign count    = wp_reg - rp_reg;
    // full when every slot holds a command
    assign cmd_full = count == (QAW+1)'(QDEPTH);
    assign q_empty  = count == '0;
    assign head     = q_mem[rp_reg[QAW-1:0]];
    // a frame-flagged status carries a read value before the status
    assign two_part = head.frame && head.kind == KIND_STATUS;

    always_comb
    begin
        case (sub_reg)
            4'd0:    fbyte = head.tid[15:8];
            4'd1:    fbyte = head.tid[7:0];
            4'd5:    fbyte = 8'd6;
            4'd6:    fbyte = head.unit;
            4'd7:    fbyte = head.func;
            4'd8:    fbyte = head.addr[15:8];
            4'd9:    fbyte = head.addr[7:0];
            4'd10:   fbyte = head.word[15:8];
            4'd11:   fbyte = head.word[7:0];
            default: fbyte = 8'd0;
        endcase
    end

    always_comb
    begin
        res = '0;
        if (head.frame && head.kind == KIND_FRAME) begin
            res.kind = KIND_FRAME;
            res.data = {8'd0, fbyte};
            res.last = sub_reg == 4'd11;
        end else if (two_part && sub_reg == 4'd0) begin
            res.kind = KIND_VALUE;
            res.data = head.data;
        end else begin
            res.kind   = head.kind;
            res.data   = head.data;
            res.status = head.status;
            res.last   = head.kind == KIND_STATUS;
            if (two_part && head.status != ST_EXCEPT)
                res.data = 16'd0;
        end
    end

    assign out_valid = !q_empty;
    assign adv       = out_valid && out_ready;
    assign pop       = adv && (res.last || res.kind == KIND_VALUE && !two_part);

    always_comb
    begin
        sub_next = sub_reg;
        if (adv)
            sub_next = pop ? 4'd0 : sub_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
            q_mem[wp_reg[QAW-1:0]] <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            sub_reg <= '0;
        end else begin
            if (cmd_valid)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            sub_reg <= sub_next;
        end
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        count <= (QAW+1)'(QDEPTH)) else $error("queue overflow");
    a_sub_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> sub_reg == 4'd0) else $error("sub-index not cleared");
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg <= 4'd11) else $error("frame index out of range");

endmodule

[src/modbus_tcp_client_framer_checker.sv]
// Modbus TCP client framer and response checker.
// Input stream s_axis: one item per transfer; tuser carries action, tdata carries
// device_id, function_req, address, word and rx_byte. Output stream m_axis: one
// result per transfer; tuser carries kind, tdata carries data and status, tlast
// marks the twelfth request byte and every final status.
// A start item yields 12 frame bytes (or one bad-argument status); a received
// byte yields at most one read value and one status (the last byte of a read or
// coil reply yields both, as two results); a timeout yields one status unless idle.
// The front part classifies an item in the cycle it is accepted and pushes at
// most one command into a four-entry queue; the back part expands commands into
// results one per cycle while the receiver takes them, so the first result of an
// item is read from the registered queue. Input is taken every cycle while the
// queue has room, so bytes stream at one per cycle.
// Reset closes the link, clears the transaction counter and empties the queue.
// When the receiver stalls the queue fills and s_axis_tready drops until a slot
// frees; no result is lost.
module modbus_tcp_client_framer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // action
    input  logic [55:0] s_axis_tdata,  // device_id, function_req, address, word, rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,  // kind
    output logic [23:0] m_axis_tdata,  // data, status, pad
    output logic        m_axis_tlast
);
    import mbtcp_pkg::*;

    logic cmd_valid, cmd_full;
    cmd_t cmd;
    res_t res;

    mbtcp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .action       (s_axis_tuser),
        .device_id    (s_axis_tdata[7:0]),
        .function_req (s_axis_tdata[15:8]),
        .address      (s_axis_tdata[31:16]),
        .word         (s_axis_tdata[47:32]),
        .rx_byte      (s_axis_tdata[55:48]),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_full     (cmd_full)
    );

    mbtcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_full  (cmd_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {4'd0, res.status, res.data};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
